/* rtl/ufr_pkg.sv */
// ----------------------------------------------------------------------------
// ufr_pkg
// Shared types and codes of the frame receiver: word layouts, request and
// event codes, frame kinds and the configuration register set.
// ----------------------------------------------------------------------------
package ufr_pkg;

  localparam int ReqTypeW  = 2;
  localparam int ByteW     = 8;
  localparam int IndexW    = 8;
  localparam int EventW    = 3;
  localparam int WordW     = 16;
  localparam int TimerW    = 16;
  localparam int KindW     = 2;
  localparam int ApbAddrW  = 4;
  localparam int ApbDataW  = 32;

  localparam logic [ReqTypeW-1:0] REQ_BYTE = 2'd0;
  localparam logic [ReqTypeW-1:0] REQ_TICK = 2'd1;
  localparam logic [ReqTypeW-1:0] REQ_READ = 2'd2;

  localparam logic [KindW-1:0] KIND_NONE  = 2'd0;
  localparam logic [KindW-1:0] KIND_WRITE = 2'd1;
  localparam logic [KindW-1:0] KIND_READ  = 2'd2;
  localparam logic [KindW-1:0] KIND_CMD   = 2'd3;

  localparam logic [EventW-1:0] EV_NONE    = 3'd0;
  localparam logic [EventW-1:0] EV_ACCEPT  = 3'd1;
  localparam logic [EventW-1:0] EV_DONE    = 3'd2;
  localparam logic [EventW-1:0] EV_BADLEN  = 3'd3;
  localparam logic [EventW-1:0] EV_READREQ = 3'd4;
  localparam logic [EventW-1:0] EV_TIMEOUT = 3'd5;
  localparam logic [EventW-1:0] EV_DROP    = 3'd6;

  // register indexes on the APB port (byte address = 4 * index)
  localparam logic [1:0] REG_START_WRITE = 2'd0;
  localparam logic [1:0] REG_START_READ  = 2'd1;
  localparam logic [1:0] REG_START_CMD   = 2'd2;
  localparam logic [1:0] REG_TIMEOUT     = 2'd3;

  localparam logic [ByteW-1:0]  START_WRITE_RESET = 8'd1;
  localparam logic [ByteW-1:0]  START_READ_RESET  = 8'd2;
  localparam logic [ByteW-1:0]  START_CMD_RESET   = 8'd3;
  localparam logic [TimerW-1:0] TIMEOUT_RESET     = 16'd100;

  typedef struct packed {
    logic [ReqTypeW-1:0] req_type;
    logic [ByteW-1:0]    rx_byte;
    logic [IndexW-1:0]   word_index;
  } req_t;

  typedef struct packed {
    logic [EventW-1:0] event_code;
    logic [WordW-1:0]  word_value;
  } rsp_t;

  typedef struct packed {
    logic [ByteW-1:0]  start_write_code;
    logic [ByteW-1:0]  start_read_code;
    logic [ByteW-1:0]  start_cmd_code;
    logic [TimerW-1:0] timeout_ticks;
  } cfg_t;

endpackage

/* rtl/ufr_if.sv */
// ----------------------------------------------------------------------------
// ufr_if
// Valid/ready channels of the frame receiver: request words in, event words
// out.
// ----------------------------------------------------------------------------
interface ufr_req_if
  import ufr_pkg::*;
;
  logic                valid;
  logic                ready;
  logic [ReqTypeW-1:0] req_type;
  logic [ByteW-1:0]    rx_byte;
  logic [IndexW-1:0]   word_index;

  modport source (output valid, output req_type, output rx_byte, output word_index,
                  input ready);
  modport sink   (input valid, input req_type, input rx_byte, input word_index,
                  output ready);
endinterface

interface ufr_rsp_if
  import ufr_pkg::*;
;
  logic              valid;
  logic              ready;
  logic [EventW-1:0] event_code;
  logic [WordW-1:0]  word_value;

  modport source (output valid, output event_code, output word_value, input ready);
  modport sink   (input valid, input event_code, input word_value, output ready);
endinterface

/* rtl/ufr_cfg.sv */
// ----------------------------------------------------------------------------
// ufr_cfg
// APB register file holding the three start codes and the idle timeout.
// ----------------------------------------------------------------------------
module ufr_cfg
  import ufr_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [ApbAddrW-1:0] paddr,
  input  logic [ApbDataW-1:0] pwdata,
  output logic [ApbDataW-1:0] prdata,
  output logic                pready,
  output cfg_t                cfg
);

  logic       wr_en;
  logic [1:0] reg_sel;

  assign pready  = 1'b1;
  assign reg_sel = paddr[3:2];
  assign wr_en   = psel & penable & pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.start_write_code <= START_WRITE_RESET;
      cfg.start_read_code  <= START_READ_RESET;
      cfg.start_cmd_code   <= START_CMD_RESET;
      cfg.timeout_ticks    <= TIMEOUT_RESET;
    end else if (wr_en) begin
      case (reg_sel)
        REG_START_WRITE: cfg.start_write_code <= pwdata[ByteW-1:0];
        REG_START_READ:  cfg.start_read_code  <= pwdata[ByteW-1:0];
        REG_START_CMD:   cfg.start_cmd_code   <= pwdata[ByteW-1:0];
        REG_TIMEOUT:     cfg.timeout_ticks    <= pwdata[TimerW-1:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      REG_START_WRITE: prdata = ApbDataW'(cfg.start_write_code);
      REG_START_READ:  prdata = ApbDataW'(cfg.start_read_code);
      REG_START_CMD:   prdata = ApbDataW'(cfg.start_cmd_code);
      REG_TIMEOUT:     prdata = ApbDataW'(cfg.timeout_ticks);
      default:         prdata = '0;
    endcase
  end

endmodule

/* rtl/ufr_parser.sv */
// ----------------------------------------------------------------------------
// ufr_parser
// Frame state, idle timer, store; decides one request word per fire cycle.
// ----------------------------------------------------------------------------
module ufr_parser
  import ufr_pkg::*;
#(
  parameter int WORD_COUNT = 8
) (
  input  logic clk,
  input  logic rst,
  input  cfg_t cfg,
  input  logic fire,
  input  req_t req,
  output rsp_t rsp
);

  localparam int StoreBytes = 2 * WORD_COUNT;
  localparam int CntW       = $clog2(StoreBytes + 2);
  localparam int AddrW      = (WORD_COUNT > 1) ? $clog2(WORD_COUNT) : 1;

  localparam logic [CntW-1:0]   CNT_LEN   = CntW'(1);
  localparam logic [CntW-1:0]   CNT_LAST  = CntW'(StoreBytes + 1);
  localparam logic [CntW-1:0]   CNT_ONE   = CntW'(1);
  localparam logic [CntW-1:0]   CNT_TWO   = CntW'(2);
  localparam logic [ByteW-1:0]  LEN_BYTE  = ByteW'(StoreBytes);
  localparam logic [TimerW-1:0] TIMER_MAX = '1;

  logic [KindW-1:0]  frame_kind,    frame_kind_next;
  logic [CntW-1:0]   byte_count,    byte_count_next;
  logic [TimerW-1:0] idle_timer,    idle_timer_next;
  logic              timer_running, timer_running_next;
  logic [WordW-1:0]  store [WORD_COUNT];

  logic              wr_en;
  logic [CntW-1:0]   pos;
  logic [AddrW-1:0]  wr_addr;
  logic [TimerW-1:0] timer_inc;

  assign pos       = byte_count - CNT_TWO;
  assign wr_addr   = AddrW'(pos >> 1);
  assign timer_inc = (idle_timer == TIMER_MAX) ? idle_timer : idle_timer + 1'b1;

  always_comb begin
    frame_kind_next    = frame_kind;
    byte_count_next    = byte_count;
    idle_timer_next    = idle_timer;
    timer_running_next = timer_running;
    wr_en              = 1'b0;
    rsp.event_code     = EV_NONE;
    rsp.word_value     = '0;

    case (req.req_type)
      REQ_BYTE: begin
        // go idle by default, override where the frame continues
        frame_kind_next    = KIND_NONE;
        byte_count_next    = '0;
        idle_timer_next    = '0;
        timer_running_next = 1'b0;
        if (byte_count == '0) begin
          rsp.event_code = EV_ACCEPT;
          if (req.rx_byte == cfg.start_write_code) begin
            frame_kind_next = KIND_WRITE;
          end else if (req.rx_byte == cfg.start_read_code) begin
            frame_kind_next = KIND_READ;
          end else if (req.rx_byte == cfg.start_cmd_code) begin
            frame_kind_next = KIND_CMD;
          end else begin
            rsp.event_code = EV_DROP;
          end
          if (rsp.event_code == EV_ACCEPT) begin
            byte_count_next    = CNT_ONE;
            timer_running_next = 1'b1;
          end
        end else begin
          case (frame_kind)
            KIND_WRITE: begin
              if (byte_count == CNT_LEN) begin
                if (req.rx_byte != LEN_BYTE) begin
                  rsp.event_code = EV_BADLEN;
                end else begin
                  rsp.event_code     = EV_ACCEPT;
                  frame_kind_next    = KIND_WRITE;
                  byte_count_next    = CNT_TWO;
                  timer_running_next = 1'b1;
                end
              end else begin
                wr_en = 1'b1;
                if (byte_count == CNT_LAST) begin
                  rsp.event_code = EV_DONE;
                end else begin
                  rsp.event_code     = EV_ACCEPT;
                  frame_kind_next    = KIND_WRITE;
                  byte_count_next    = byte_count + CNT_ONE;
                  timer_running_next = 1'b1;
                end
              end
            end
            KIND_READ: rsp.event_code = EV_READREQ;
            default:   rsp.event_code = EV_DROP;
          endcase
        end
      end
      REQ_TICK: begin
        if (timer_running) begin
          if (timer_inc >= cfg.timeout_ticks) begin
            rsp.event_code     = EV_TIMEOUT;
            frame_kind_next    = KIND_NONE;
            byte_count_next    = '0;
            idle_timer_next    = '0;
            timer_running_next = 1'b0;
          end else begin
            idle_timer_next = timer_inc;
          end
        end
      end
      REQ_READ: begin
        if ({1'b0, req.word_index} < (IndexW + 1)'(WORD_COUNT)) begin
          rsp.word_value = store[AddrW'(req.word_index)];
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_kind    <= KIND_NONE;
      byte_count    <= '0;
      idle_timer    <= '0;
      timer_running <= 1'b0;
      for (int i = 0; i < WORD_COUNT; i++) begin
        store[i] <= '0;
      end
    end else if (fire) begin
      frame_kind    <= frame_kind_next;
      byte_count    <= byte_count_next;
      idle_timer    <= idle_timer_next;
      timer_running <= timer_running_next;
      // payload lands little-endian, low byte at even positions
      if (wr_en) begin
        if (pos[0]) begin
          store[wr_addr][15:8] <= req.rx_byte;
        end else begin
          store[wr_addr][7:0] <= req.rx_byte;
        end
      end
    end
  end

endmodule

/* rtl/uart_frame_receiver.sv */
// ----------------------------------------------------------------------------
// uart_frame_receiver
// Start/length/payload frame parser with an APB register port.
// A single decision stage sits between the input stage and the result stage.
// Throughput: one request word per cycle while rsp.ready is high.
// Reset (rst, synchronous): parser idle, timer stopped, word store cleared,
// registers at their defaults, both pipeline stages empty.
// ----------------------------------------------------------------------------
module uart_frame_receiver
  import ufr_pkg::*;
#(
  parameter int WORD_COUNT = 8
) (
  input  logic                clk,
  input  logic                rst,
  ufr_req_if.sink             req,
  ufr_rsp_if.source           rsp,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [ApbAddrW-1:0] paddr,
  input  logic [ApbDataW-1:0] pwdata,
  output logic [ApbDataW-1:0] prdata,
  output logic                pready
);

  cfg_t cfg;

  // input stage: holds one accepted request word
  logic in_valid;
  req_t in_word;

  // result stage: holds one event word until the sink takes it
  logic out_valid;
  rsp_t out_word;

  rsp_t decide_rsp;
  logic advance;

  ufr_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // Advance the input stage whenever the result stage is empty or draining;
  // the frame state is committed on the same edge, so the next request sees
  // it without a bubble.
  assign advance   = in_valid & (~out_valid | rsp.ready);
  assign req.ready = ~in_valid | advance;

  ufr_parser #(
    .WORD_COUNT (WORD_COUNT)
  ) u_parser (
    .clk  (clk),
    .rst  (rst),
    .cfg  (cfg),
    .fire (advance),
    .req  (in_word),
    .rsp  (decide_rsp)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (req.ready) begin
      in_valid <= req.valid;
    end
  end

  // payload: load on accept, hold otherwise
  always_ff @(posedge clk) begin
    if (req.valid & req.ready) begin
      in_word.req_type   <= req.req_type;
      in_word.rx_byte    <= req.rx_byte;
      in_word.word_index <= req.word_index;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_word <= decide_rsp;
    end
  end

  assign rsp.valid      = out_valid;
  assign rsp.event_code = out_word.event_code;
  assign rsp.word_value = out_word.word_value;

endmodule
